@@ src/hsvl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to LED pixel frame: shared package
// Beat types, fixed-point constants and the hue sector codes used by the
// conversion pipeline.
// ----------------------------------------------------------------------------
package hsvl_pkg;

	// Number of LEDs on the strip; an index at or above it is rejected.
	localparam logic [8:0] PIXEL_COUNT = 9'd144;

	// Hue is in 1/64 degree: 60 degrees per sector, 360 degrees full circle.
	localparam logic [15:0] HUE_SECTOR = 16'd3840;
	localparam logic [15:0] HUE_FULL   = 16'd23040;

	// Q8 fraction one.
	localparam logic [8:0] Q8_ONE = 9'd256;

	// Leading marker bits of an LED frame word and the width of its level field.
	localparam logic [2:0] FRAME_MARK = 3'b111;
	localparam int         LEVEL_W    = 5;

	// ceil(65536 / 15); (n * RECIP_15) >> 16 equals n / 15 for n below 4681.
	localparam logic [12:0] RECIP_15 = 13'd4370;

	// Hue sectors, named by the colors at their two ends.
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// One input beat.
	typedef struct packed {
		logic [7:0]  pixel_index;
		logic [15:0] hue;
		logic [8:0]  saturation;
		logic [8:0]  brightness_value;
		logic [7:0]  global_level;
	} hsv_beat_t;

	// One result beat.
	typedef struct packed {
		logic        index_ok;
		logic [7:0]  pixel_out_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [31:0] led_frame;
	} led_beat_t;

endpackage

@@ src/hsvl_chan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to LED pixel frame: channel scaler
// Adds the value offset to one color component and scales the Q8 sum to an
// 8-bit channel, forcing black when the pixel is not drawn.
// ----------------------------------------------------------------------------
module hsvl_chan (
	input  logic [8:0] chan,
	input  logic [8:0] offset,
	input  logic       keep,
	output logic [7:0] level
);
	import hsvl_pkg::*;

	logic [8:0]  sum;
	logic [16:0] scaled;

	// The sum never exceeds one in Q8, so it fits nine bits.
	assign sum = chan + offset;

	// Multiply by 255 as a shift and a subtract, then drop the Q8 fraction.
	assign scaled = {sum, 8'b0} - {8'b0, sum};

	assign level = keep ? scaled[15:8] : 8'd0;

endmodule

@@ src/hsv_to_led_pixel_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to LED pixel frame converter
// Converts one HSV pixel per cycle, while the output is not stalled, to 8-bit RGB and packs a serial LED word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (hsv_valid, hsv_stall, hsv_beat) takes a pixel index,
//   hue in 1/64 degree, Q8 saturation and value, and a global level. The
//   output channel (led_valid, led_stall, led_beat) returns one beat per
//   input beat, in order: the index check, the index, red, green, blue and
//   the 32-bit LED frame word.
//   An accepted beat passes the four register stages (product, weighted
//   chroma, second component, output) in order to the output. Throughput
//   is one beat per cycle while led_stall is low; each stage takes a new
//   beat every cycle unless it holds a beat that cannot move on.
//   When the receiver stalls, the output beat holds and the stages behind it
//   keep filling until they are full; only then is hsv_stall raised. Empty
//   stages never block, so bubbles are squeezed out.
//   Reset clears all stage valid bits; the block comes out of reset empty
//   and ready, with led_valid low.
// ----------------------------------------------------------------------------
module hsv_to_led_pixel_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hsv_valid,
	output logic                 hsv_stall,
	input  hsvl_pkg::hsv_beat_t  hsv_beat,
	output logic                 led_valid,
	input  logic                 led_stall,
	output hsvl_pkg::led_beat_t  led_beat
);
	import hsvl_pkg::*;

	// Stage advance enables, from the output backward.
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	// Stage 0 combinational results.
	logic [8:0]  sat_c;
	logic [8:0]  val_c;
	logic [17:0] prod_c;
	logic        ok_c;
	logic        black_c;
	sector_t     sector_c;
	logic [15:0] base_c;
	logic [11:0] resid_c;
	logic [11:0] weight_c;

	// Stage 1 registers.
	logic        valid_s1;
	logic [7:0]  idx_s1;
	logic        ok_s1;
	logic        black_s1;
	logic [4:0]  lvl_s1;
	logic [8:0]  val_s1;
	logic [16:0] prod_s1;
	sector_t     sector_s1;
	logic [11:0] weight_s1;

	// Stage 2 registers and their inputs.
	logic [8:0]  chroma_c;
	logic [20:0] cw_c;
	logic        valid_s2;
	logic [7:0]  idx_s2;
	logic        ok_s2;
	logic        black_s2;
	logic [4:0]  lvl_s2;
	logic [8:0]  offset_s2;
	logic [8:0]  chroma_s2;
	logic [19:0] cw_s2;
	sector_t     sector_s2;

	// Stage 3 registers and their inputs.
	logic [24:0] xprod_c;
	logic        valid_s3;
	logic [7:0]  idx_s3;
	logic        ok_s3;
	logic        black_s3;
	logic [4:0]  lvl_s3;
	logic [8:0]  offset_s3;
	logic [8:0]  chroma_s3;
	logic [8:0]  xcomp_s3;
	sector_t     sector_s3;

	// Stage 4 inputs and the output register.
	logic [8:0]  rp_c, gp_c, bp_c;
	logic [7:0]  red_c, green_c, blue_c;
	logic        keep_c;
	logic        valid_s4;
	led_beat_t   beat_s4;

	// A stage takes a new beat when it is empty or its beat moves on.
	assign adv_s4    = !valid_s4 || !led_stall;
	assign adv_s3    = !valid_s3 || adv_s4;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign hsv_stall = !adv_s1;

	// Clamp saturation and value to one and form their product.
	assign sat_c  = (hsv_beat.saturation > Q8_ONE) ? Q8_ONE : hsv_beat.saturation;
	assign val_c  = (hsv_beat.brightness_value > Q8_ONE) ? Q8_ONE
		: hsv_beat.brightness_value;
	assign prod_c  = 18'(sat_c) * 18'(val_c);
	assign ok_c    = {1'b0, hsv_beat.pixel_index} < PIXEL_COUNT;
	assign black_c = hsv_beat.hue >= HUE_FULL;

	// Find the hue sector by comparing against the sector boundaries.
	always_comb begin
		priority if (hsv_beat.hue >= 16'(5 * HUE_SECTOR)) begin
			sector_c = SEC_MAG_RED;
			base_c   = 16'(5 * HUE_SECTOR);
		end else if (hsv_beat.hue >= 16'(4 * HUE_SECTOR)) begin
			sector_c = SEC_BLU_MAG;
			base_c   = 16'(4 * HUE_SECTOR);
		end else if (hsv_beat.hue >= 16'(3 * HUE_SECTOR)) begin
			sector_c = SEC_CYN_BLU;
			base_c   = 16'(3 * HUE_SECTOR);
		end else if (hsv_beat.hue >= 16'(2 * HUE_SECTOR)) begin
			sector_c = SEC_GRN_CYN;
			base_c   = 16'(2 * HUE_SECTOR);
		end else if (hsv_beat.hue >= HUE_SECTOR) begin
			sector_c = SEC_YEL_GRN;
			base_c   = HUE_SECTOR;
		end else begin
			sector_c = SEC_RED_YEL;
			base_c   = 16'd0;
		end
	end

	// Offset into the sector; the hue weight rises in even sectors and falls
	// in odd ones. A black hue leaves an out-of-range residue that is unused.
	assign resid_c = 12'(hsv_beat.hue - base_c);

	always_comb begin
		unique case (sector_c)
			SEC_YEL_GRN, SEC_CYN_BLU, SEC_MAG_RED: begin
				weight_c = 12'(HUE_SECTOR) - resid_c;
			end
			default: begin
				weight_c = resid_c;
			end
		endcase
	end

	// Stage 1: product of saturation and value, sector and hue weight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= hsv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			idx_s1    <= hsv_beat.pixel_index;
			ok_s1     <= ok_c;
			black_s1  <= black_c;
			lvl_s1    <= hsv_beat.global_level[LEVEL_W-1:0];
			val_s1    <= val_c;
			prod_s1   <= prod_c[16:0];
			sector_s1 <= sector_c;
			weight_s1 <= weight_c;
		end
	end

	// Chroma in Q8 and its product with the hue weight.
	assign chroma_c = prod_s1[16:8];
	assign cw_c     = 21'(chroma_c) * 21'(weight_s1);

	// Stage 2: chroma, value offset and the weighted chroma.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			idx_s2    <= idx_s1;
			ok_s2     <= ok_s1;
			black_s2  <= black_s1;
			lvl_s2    <= lvl_s1;
			offset_s2 <= val_s1 - chroma_c;
			chroma_s2 <= chroma_c;
			cw_s2     <= cw_c[19:0];
			sector_s2 <= sector_s1;
		end
	end

	// Divide by 3840 as a shift by 256 and a reciprocal multiply for 15.
	assign xprod_c = 25'(cw_s2[19:8]) * 25'(RECIP_15);

	// Stage 3: second color component.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			idx_s3    <= idx_s2;
			ok_s3     <= ok_s2;
			black_s3  <= black_s2;
			lvl_s3    <= lvl_s2;
			offset_s3 <= offset_s2;
			chroma_s3 <= chroma_s2;
			xcomp_s3  <= xprod_c[24:16];
			sector_s3 <= sector_s2;
		end
	end

	// Route chroma and the second component to the channels of the sector.
	always_comb begin
		unique case (sector_s3)
			SEC_RED_YEL: begin
				rp_c = chroma_s3; gp_c = xcomp_s3;  bp_c = 9'd0;
			end
			SEC_YEL_GRN: begin
				rp_c = xcomp_s3;  gp_c = chroma_s3; bp_c = 9'd0;
			end
			SEC_GRN_CYN: begin
				rp_c = 9'd0;      gp_c = chroma_s3; bp_c = xcomp_s3;
			end
			SEC_CYN_BLU: begin
				rp_c = 9'd0;      gp_c = xcomp_s3;  bp_c = chroma_s3;
			end
			SEC_BLU_MAG: begin
				rp_c = xcomp_s3;  gp_c = 9'd0;      bp_c = chroma_s3;
			end
			default: begin
				rp_c = chroma_s3; gp_c = 9'd0;      bp_c = xcomp_s3;
			end
		endcase
	end

	assign keep_c = ok_s3 && !black_s3;

	hsvl_chan u_chan_red (
		.chan   (rp_c),
		.offset (offset_s3),
		.keep   (keep_c),
		.level  (red_c)
	);

	hsvl_chan u_chan_green (
		.chan   (gp_c),
		.offset (offset_s3),
		.keep   (keep_c),
		.level  (green_c)
	);

	hsvl_chan u_chan_blue (
		.chan   (bp_c),
		.offset (offset_s3),
		.keep   (keep_c),
		.level  (blue_c)
	);

	// Stage 4: output register with the packed LED frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			beat_s4.index_ok        <= ok_s3;
			beat_s4.pixel_out_index <= idx_s3;
			beat_s4.red             <= red_c;
			beat_s4.green           <= green_c;
			beat_s4.blue            <= blue_c;
			beat_s4.led_frame       <= ok_s3
				? {FRAME_MARK, lvl_s3, blue_c, green_c, red_c} : 32'd0;
		end
	end

	assign led_valid = valid_s4;
	assign led_beat  = beat_s4;

endmodule
